>>> sv/avr_pkg.sv
// ---------------------------------------------------------------------------
// avr_pkg: shared types, codes and sine table for the vertex axis rotator
// Holds the quarter-wave sine table in Q30, the pipeline stage structs and
// the angle-to-quadrant reduction used by the coefficient stage.
// ---------------------------------------------------------------------------
package avr_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 9;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = COORD_W + COEF_W;
    localparam int IDX_W    = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // defaults and limits
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(360);
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] ANGLE_HALF = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] ANGLE_THREE_Q = ANGLE_W'(270);

    // request function codes
    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // register index (paddr bit 2)
    localparam logic REG_AXIS_SELECT = 1'b0;

    // rotation axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // quarter-wave lookup address and sign
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_quad;

    // input register stage
    typedef struct packed {
        t_axis                      axis;
        logic [ANGLE_W-1:0]         angle;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } t_stage_in;

    // coefficient stage
    typedef struct packed {
        t_axis                      axis;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [COEF_W-1:0]   cos_c;
        logic signed [COEF_W-1:0]   sin_c;
    } t_stage_coef;

    // product stage: a and b are the two coordinates that turn
    typedef struct packed {
        t_axis                      axis;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [PROD_W-1:0]   p_ac;
        logic signed [PROD_W-1:0]   p_bs;
        logic signed [PROD_W-1:0]   p_as;
        logic signed [PROD_W-1:0]   p_bc;
    } t_stage_prod;

    // result vertex
    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } t_vertex;

    typedef logic [90:0][30:0] t_sin_tab;

    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;

    // unsigned long division by shift and subtract
    function automatic longint unsigned div_u64(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin of 0..90 degrees in Q30, Taylor series with rounded terms
    function automatic t_sin_tab build_sin_q30();
        t_sin_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint sum;
        for (int k = 0; k <= 90; k++) begin
            if (k == 0) begin
                tab[k] = '0;
            end else if (k == 90) begin
                tab[k] = 31'(Q30_ONE);
            end else begin
                x = longint'(k) * RAD_PER_DEG_Q30;
                x2 = (x * x + Q30_HALF) >> 30;
                term = x;
                sum = longint'(x);
                for (int n = 1; n <= 10; n++) begin
                    d = longint'(2 * n) * longint'(2 * n + 1);
                    term = (div_u64(term * x2, d) + Q30_HALF) >> 30;
                    if (n % 2 == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                if (sum > longint'(Q30_ONE)) begin
                    sum = longint'(Q30_ONE);
                end
                tab[k] = sum[30:0];
            end
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_Q30 = build_sin_q30();

    // fold 0..511 degrees onto the quarter wave
    function automatic t_quad reduce_deg(input logic [ANGLE_W-1:0] deg);
        logic [ANGLE_W-1:0] d;
        t_quad q;
        d = (deg >= ANGLE_MAX) ? deg - ANGLE_MAX : deg;
        if (d <= ANGLE_QUARTER) begin
            q.idx = d[IDX_W-1:0];
            q.neg = 1'b0;
        end else if (d <= ANGLE_HALF) begin
            q.idx = IDX_W'(ANGLE_HALF - d);
            q.neg = 1'b0;
        end else if (d <= ANGLE_THREE_Q) begin
            q.idx = IDX_W'(d - ANGLE_HALF);
            q.neg = 1'b1;
        end else begin
            q.idx = IDX_W'(ANGLE_MAX - d);
            q.neg = 1'b1;
        end
        return q;
    endfunction

endpackage

>>> sv/avr_coef.sv
// ---------------------------------------------------------------------------
// avr_coef: sine and cosine coefficient stage
// Looks up the quarter-wave table for the captured angle, rounds to the
// coordinate fraction width and applies the quadrant sign.
// ---------------------------------------------------------------------------
module avr_coef #(
    parameter int FRAC_BITS = avr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  avr_pkg::t_stage_in   i_stage,
    output avr_pkg::t_stage_coef o_stage
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic [31:0] HALF = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;

    avr_pkg::t_quad        sin_q;
    avr_pkg::t_quad        cos_q;
    logic [31:0]           sin_mag;
    logic [31:0]           cos_mag;
    avr_pkg::t_stage_coef  n_stage;
    avr_pkg::t_stage_coef  r_stage;

    // quadrant folding, cos(k) = sin(k + 90)
    always_comb begin
        sin_q = avr_pkg::reduce_deg(i_stage.angle);
        cos_q = avr_pkg::reduce_deg(i_stage.angle + avr_pkg::ANGLE_QUARTER);
    end

    // table read and rounding to the coordinate format
    always_comb begin
        sin_mag = ({1'b0, avr_pkg::SIN_Q30[sin_q.idx]} + HALF) >> SH;
        cos_mag = ({1'b0, avr_pkg::SIN_Q30[cos_q.idx]} + HALF) >> SH;
    end

    // next stage contents
    always_comb begin
        n_stage.axis  = i_stage.axis;
        n_stage.x     = i_stage.x;
        n_stage.y     = i_stage.y;
        n_stage.z     = i_stage.z;
        n_stage.sin_c = sin_q.neg ? -$signed(sin_mag) : $signed(sin_mag);
        n_stage.cos_c = cos_q.neg ? -$signed(cos_mag) : $signed(cos_mag);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> sv/avr_mul.sv
// ---------------------------------------------------------------------------
// avr_mul: product stage
// Picks the two coordinates that turn about the selected axis and forms
// the four coefficient products.
// ---------------------------------------------------------------------------
module avr_mul (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  avr_pkg::t_stage_coef i_stage,
    output avr_pkg::t_stage_prod o_stage
);

    logic signed [avr_pkg::COORD_W-1:0] a;
    logic signed [avr_pkg::COORD_W-1:0] b;
    avr_pkg::t_stage_prod               n_stage;
    avr_pkg::t_stage_prod               r_stage;

    // operand pair: a*c - b*s and a*s + b*c give the turned coordinates
    always_comb begin
        case (i_stage.axis)
            avr_pkg::AXIS_Y: begin
                a = i_stage.z;
                b = i_stage.x;
            end
            avr_pkg::AXIS_Z: begin
                a = i_stage.x;
                b = i_stage.y;
            end
            default: begin
                a = i_stage.y;
                b = i_stage.z;
            end
        endcase
    end

    // products
    always_comb begin
        n_stage.axis = i_stage.axis;
        n_stage.x    = i_stage.x;
        n_stage.y    = i_stage.y;
        n_stage.z    = i_stage.z;
        n_stage.p_ac = a * i_stage.cos_c;
        n_stage.p_bs = b * i_stage.sin_c;
        n_stage.p_as = a * i_stage.sin_c;
        n_stage.p_bc = b * i_stage.cos_c;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> sv/avr_sum.sv
// ---------------------------------------------------------------------------
// avr_sum: sum, rounding and saturation stage
// Adds the product pairs, rounds half up at the fraction point, saturates
// to 16 bits and places the results by axis into the result register.
// ---------------------------------------------------------------------------
module avr_sum #(
    parameter int FRAC_BITS = avr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  avr_pkg::t_stage_prod i_stage,
    output avr_pkg::t_vertex     o_vertex
);

    localparam int SUM_W = avr_pkg::PROD_W + 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    logic signed [SUM_W-1:0]            sum_r1;
    logic signed [SUM_W-1:0]            sum_r2;
    logic signed [avr_pkg::COORD_W-1:0] rot_1;
    logic signed [avr_pkg::COORD_W-1:0] rot_2;
    avr_pkg::t_vertex                   n_vertex;
    avr_pkg::t_vertex                   r_vertex;

    // round half up, then clamp
    function automatic logic signed [avr_pkg::COORD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] t;
        t = (v + HALF) >>> FRAC_BITS;
        if (t > SAT_HI) begin
            return SAT_HI[avr_pkg::COORD_W-1:0];
        end else if (t < SAT_LO) begin
            return SAT_LO[avr_pkg::COORD_W-1:0];
        end
        return t[avr_pkg::COORD_W-1:0];
    endfunction

    // the two turned coordinates
    always_comb begin
        sum_r1 = SUM_W'(i_stage.p_ac) - SUM_W'(i_stage.p_bs);
        sum_r2 = SUM_W'(i_stage.p_as) + SUM_W'(i_stage.p_bc);
        rot_1  = round_sat(sum_r1);
        rot_2  = round_sat(sum_r2);
    end

    // place results by axis, the axis coordinate passes unchanged
    always_comb begin
        n_vertex.x = i_stage.x;
        n_vertex.y = i_stage.y;
        n_vertex.z = i_stage.z;
        case (i_stage.axis)
            avr_pkg::AXIS_X: begin
                n_vertex.y = rot_1;
                n_vertex.z = rot_2;
            end
            avr_pkg::AXIS_Y: begin
                n_vertex.z = rot_1;
                n_vertex.x = rot_2;
            end
            avr_pkg::AXIS_Z: begin
                n_vertex.x = rot_1;
                n_vertex.y = rot_2;
            end
            default: begin
                n_vertex.x = i_stage.x;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vertex <= n_vertex;
        end
    end

    assign o_vertex = r_vertex;

endmodule

>>> sv/vertex_axis_rotator_top.sv
// ---------------------------------------------------------------------------
// vertex_axis_rotator_top: rotates vertices about a principal axis
// Four-stage pipeline: input register, coefficient lookup, products,
// sum/round/saturate into the result register.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one request per cycle while o_stall is low.
//   A tick request (i_func = 1) advances the stored angle by one degree, wrapping
//   from 360 to 0, and gives no result. A vertex request (i_func = 0) gives
//   one rotated vertex on the output channel (o_valid / i_stall).
//   A vertex passes the input, coefficient, product and result registers before o_valid.
//   Throughput: one request per cycle while o_stall is low, set by the single
//   multiply stage of four parallel 16x32 multipliers.
//   A vertex uses the angle in force when it is accepted; a following tick
//   does not touch vertices already in the pipeline.
//   axis_select sits at APB byte address 0 (0 x, 1 y, 2 z, 3 pass through).
//   Reset clears the angle, axis_select and all stage valid bits.
//   When i_stall holds the result, the pipeline closes up its empty stages;
//   o_stall rises once all four stages hold vertices.
// ---------------------------------------------------------------------------
module vertex_axis_rotator_top #(
    parameter int COORD_FRAC_BITS = avr_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic signed [avr_pkg::COORD_W-1:0]  i_x_in,
    input  logic signed [avr_pkg::COORD_W-1:0]  i_y_in,
    input  logic signed [avr_pkg::COORD_W-1:0]  i_z_in,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [avr_pkg::COORD_W-1:0]  o_x_out,
    output logic signed [avr_pkg::COORD_W-1:0]  o_y_out,
    output logic signed [avr_pkg::COORD_W-1:0]  o_z_out,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [avr_pkg::PADDR_W-1:0]         paddr,
    input  logic [avr_pkg::PDATA_W-1:0]         pwdata,
    output logic [avr_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    logic                         r_va;
    logic                         r_vb;
    logic                         r_vc;
    logic                         r_vd;
    logic                         en_a;
    logic                         en_b;
    logic                         en_c;
    logic                         en_d;
    logic                         in_acc;
    logic                         cfg_wr;
    avr_pkg::t_axis               r_axis;
    logic [avr_pkg::ANGLE_W-1:0]  r_angle;
    logic [avr_pkg::ANGLE_W-1:0]  n_angle;
    avr_pkg::t_stage_in           r_stage_in;
    avr_pkg::t_stage_in           n_stage_in;
    avr_pkg::t_stage_coef         stage_coef;
    avr_pkg::t_stage_prod         stage_prod;
    avr_pkg::t_vertex             result;

    // stage advance: a stage loads when the one after it is empty or moving
    assign en_d   = !r_vd || !i_stall;
    assign en_c   = !r_vc || en_d;
    assign en_b   = !r_vb || en_c;
    assign en_a   = !r_va || en_b;
    assign o_stall = !en_a;
    assign in_acc = i_valid && !o_stall;

    // configuration writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == avr_pkg::REG_AXIS_SELECT) begin
            prdata = avr_pkg::PDATA_W'(r_axis);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= avr_pkg::AXIS_X;
        end else if (cfg_wr && paddr[2] == avr_pkg::REG_AXIS_SELECT) begin
            r_axis <= avr_pkg::t_axis'(pwdata[1:0]);
        end
    end

    // angle counter, wraps past 360 to 0
    always_comb begin
        n_angle = r_angle;
        if (in_acc && i_func == avr_pkg::FUNC_TICK) begin
            n_angle = (r_angle >= avr_pkg::ANGLE_MAX) ? '0
                                                      : r_angle + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else begin
            r_angle <= n_angle;
        end
    end

    // input register
    always_comb begin
        n_stage_in.axis  = r_axis;
        n_stage_in.angle = r_angle;
        n_stage_in.x     = i_x_in;
        n_stage_in.y     = i_y_in;
        n_stage_in.z     = i_z_in;
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_stage_in <= n_stage_in;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= in_acc && i_func == avr_pkg::FUNC_VERTEX;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
        end
    end

    // pipeline stages
    avr_coef #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_en    (en_b),
        .i_stage (r_stage_in),
        .o_stage (stage_coef)
    );

    avr_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (en_c),
        .i_stage (stage_coef),
        .o_stage (stage_prod)
    );

    avr_sum #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_sum (
        .i_clk    (i_clk),
        .i_en     (en_d),
        .i_stage  (stage_prod),
        .o_vertex (result)
    );

    // result channel
    assign o_valid = r_vd;
    assign o_x_out = result.x;
    assign o_y_out = result.y;
    assign o_z_out = result.z;

    // checks
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= avr_pkg::ANGLE_MAX)
        else $error("angle beyond 360");

    a_angle_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == avr_pkg::FUNC_TICK && r_angle == avr_pkg::ANGLE_MAX)
        |=> (r_angle == '0))
        else $error("angle did not wrap to zero");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_va && r_vb && r_vc && r_vd && i_stall))
        else $error("input stalled with room in the pipeline");

    a_vertex_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == avr_pkg::FUNC_VERTEX) |=> r_va)
        else $error("accepted vertex lost at input register");

endmodule

>>> bench/vertex_axis_rotator_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_axis_rotator_top_tb: self-checking bench for the vertex axis rotator
// Sends tick and vertex requests under several idle and stall mixes and every
// axis setting. Each vertex is predicted from a locally built sine table and
// checked in order against the result stream.
// ---------------------------------------------------------------------------
module vertex_axis_rotator_top_tb;

    localparam int FRAC_BITS       = 14;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 6;
    localparam int PIPE_SETTLE     = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;
    localparam logic [avr_pkg::PADDR_W-1:0] AXIS_SELECT_ADDR =
        avr_pkg::PADDR_W'(4 * avr_pkg::REG_AXIS_SELECT);
    localparam logic signed [avr_pkg::COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [avr_pkg::COORD_W-1:0] COORD_MIN = 16'sh8000;

    // rotation predictor and in-order store of expected vertices
    class rotation_scoreboard;
        int                 sin_q14[360];
        avr_pkg::t_axis     axis;
        int unsigned        angle;
        avr_pkg::t_vertex   expected_q[$];
        int                 mismatches;
        int                 vertices_checked;
        int                 ticks_seen;
        int                 angle_wraps;

        function new();
            for (int d = 0; d < 360; d++) begin
                sin_q14[d] = signed_sine(d);
            end
            axis = avr_pkg::AXIS_X;
            angle = 0;
            mismatches = 0;
            vertices_checked = 0;
            ticks_seen = 0;
            angle_wraps = 0;
        endfunction

        // sin of 0..90 degrees in Q30, rounded Taylor terms
        function longint quarter_sine_q30(int unsigned k);
            longint unsigned rad;
            longint unsigned rad_sq;
            longint unsigned term;
            longint unsigned div;
            longint acc;
            if (k == 0) return 0;
            if (k >= 90) return longint'(1) << 30;
            rad = 64'(k) * DEG_TO_RAD_Q30;
            rad_sq = (rad * rad + (64'd1 << 29)) >> 30;
            term = rad;
            acc = longint'(rad);
            for (int n = 1; n <= 10; n++) begin
                div = 64'(2 * n) * 64'(2 * n + 1);
                term = ((term * rad_sq) / div + (64'd1 << 29)) >> 30;
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) acc = 0;
            if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
            return acc;
        endfunction

        // signed Q14 sine for 0..359 degrees
        function int signed_sine(int d);
            int     q;
            bit     neg;
            longint s;
            neg = 1'b0;
            if (d <= 90) begin
                q = d;
            end else if (d <= 180) begin
                q = 180 - d;
            end else if (d <= 270) begin
                q = d - 180;
                neg = 1'b1;
            end else begin
                q = 360 - d;
                neg = 1'b1;
            end
            s = (quarter_sine_q30(q) + (longint'(1) << (29 - FRAC_BITS)))
                >>> (30 - FRAC_BITS);
            return neg ? -int'(s) : int'(s);
        endfunction

        // round half up at the fraction point, then clamp to 16 bits
        function logic signed [avr_pkg::COORD_W-1:0] round_sat(longint acc);
            longint r;
            r = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[avr_pkg::COORD_W-1:0];
        endfunction

        function avr_pkg::t_vertex rotate(logic signed [avr_pkg::COORD_W-1:0] x,
                                          logic signed [avr_pkg::COORD_W-1:0] y,
                                          logic signed [avr_pkg::COORD_W-1:0] z);
            longint           px;
            longint           py;
            longint           pz;
            longint           c;
            longint           s;
            longint           one;
            avr_pkg::t_vertex v;
            px = x;
            py = y;
            pz = z;
            s = sin_q14[angle % 360];
            c = sin_q14[(angle + 90) % 360];
            one = longint'(1) << FRAC_BITS;
            case (axis)
                avr_pkg::AXIS_X: begin
                    v.x = round_sat(px * one);
                    v.y = round_sat(py * c - pz * s);
                    v.z = round_sat(py * s + pz * c);
                end
                avr_pkg::AXIS_Y: begin
                    v.x = round_sat(px * c + pz * s);
                    v.y = round_sat(py * one);
                    v.z = round_sat(pz * c - px * s);
                end
                avr_pkg::AXIS_Z: begin
                    v.x = round_sat(px * c - py * s);
                    v.y = round_sat(px * s + py * c);
                    v.z = round_sat(pz * one);
                end
                default: begin
                    v.x = x;
                    v.y = y;
                    v.z = z;
                end
            endcase
            return v;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
        endfunction

        // accepted request: advance the angle or queue the rotated vertex
        function void note_request(logic func, logic signed [avr_pkg::COORD_W-1:0] x,
                                   logic signed [avr_pkg::COORD_W-1:0] y,
                                   logic signed [avr_pkg::COORD_W-1:0] z);
            if (func == avr_pkg::FUNC_TICK) begin
                ticks_seen++;
                if (angle + 1 > 360) begin
                    angle = 0;
                    angle_wraps++;
                end else begin
                    angle = angle + 1;
                end
            end else begin
                expected_q.push_back(rotate(x, y, z));
            end
        endfunction

        function void check_vertex(avr_pkg::t_vertex got);
            avr_pkg::t_vertex want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected vertex (%0d, %0d, %0d)", got.x, got.y, got.z));
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                flag($sformatf("vertex %0d: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                               vertices_checked, want.x, want.y, want.z, got.x, got.y, got.z));
            end
            vertices_checked++;
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic                                i_func = avr_pkg::FUNC_VERTEX;
    logic signed [avr_pkg::COORD_W-1:0]  i_x_in = '0;
    logic signed [avr_pkg::COORD_W-1:0]  i_y_in = '0;
    logic signed [avr_pkg::COORD_W-1:0]  i_z_in = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [avr_pkg::COORD_W-1:0]  o_x_out;
    logic signed [avr_pkg::COORD_W-1:0]  o_y_out;
    logic signed [avr_pkg::COORD_W-1:0]  o_z_out;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [avr_pkg::PADDR_W-1:0]         paddr = '0;
    logic [avr_pkg::PDATA_W-1:0]         pwdata = '0;
    logic [avr_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;

    rotation_scoreboard sb;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 cycle_count = 0;
    int                 axis_writes = 0;

    vertex_axis_rotator_top #(
        .COORD_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .i_x_in  (i_x_in),
        .i_y_in  (i_y_in),
        .i_z_in  (i_z_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_x_out (o_x_out),
        .o_y_out (o_y_out),
        .o_z_out (o_z_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("vertex_axis_rotator_top_tb failed");
            $finish;
        end
    end

    // random result-side stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_vertex(avr_pkg::t_vertex'{o_x_out, o_y_out, o_z_out});
        end
    end

    // present one request, hold it until accepted
    task automatic send_request(logic func, logic signed [avr_pkg::COORD_W-1:0] x,
                                logic signed [avr_pkg::COORD_W-1:0] y,
                                logic signed [avr_pkg::COORD_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_x_in <= x;
        i_y_in <= y;
        i_z_in <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(func, x, y, z);
    endtask

    // stop sending until every vertex has come out
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // apb write of axis_select, then read back
    task automatic write_axis(avr_pkg::t_axis value);
        logic [avr_pkg::PDATA_W-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AXIS_SELECT_ADDR;
        pwdata <= avr_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.axis = value;
        axis_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== avr_pkg::PDATA_W'(value)) begin
            sb.flag($sformatf("axis_select read %0d, wrote %0d", readback, value));
        end
    endtask

    // coordinate mix: extremes, small values, full range
    function automatic logic signed [avr_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return avr_pkg::COORD_W'(int'($urandom_range(16)) - 8);
            default: return avr_pkg::COORD_W'($urandom_range(65535));
        endcase
    endfunction

    // phase plan: axis setting, idle mix and stall mix
    avr_pkg::t_axis axis_plan[NUM_PHASES] = '{avr_pkg::AXIS_X, avr_pkg::AXIS_Y,
                                              avr_pkg::AXIS_Z, avr_pkg::AXIS_NONE,
                                              avr_pkg::AXIS_Z, avr_pkg::AXIS_Y};
    int    send_plan[NUM_PHASES] = '{0, 63, 0, 28, 0, 28};
    int    recv_plan[NUM_PHASES] = '{0, 0, 63, 28, 0, 28};

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset axis, zero angle, three ticks, extremes and saturation
        send_request(avr_pkg::FUNC_VERTEX, COORD_MAX, COORD_MIN, 16'sd0);
        send_request(avr_pkg::FUNC_VERTEX, COORD_MIN, COORD_MAX, -16'sd1);
        send_request(avr_pkg::FUNC_VERTEX, 16'sd0, 16'sd0, 16'sd0);
        send_request(avr_pkg::FUNC_VERTEX, 16'sd1, -16'sd1, 16'sd16384);
        send_request(avr_pkg::FUNC_TICK, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(avr_pkg::FUNC_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(avr_pkg::FUNC_VERTEX, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(avr_pkg::FUNC_VERTEX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_request(avr_pkg::FUNC_TICK, 16'sd0, 16'sd0, 16'sd0);
        send_request(avr_pkg::FUNC_TICK, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(avr_pkg::FUNC_VERTEX, COORD_MAX, COORD_MIN, COORD_MAX);
        send_request(avr_pkg::FUNC_VERTEX, -16'sd16384, 16'sd16383, -16'sd2);
        pause_until_drained();

        // random phases, angle walks past 360 and wraps
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_axis(axis_plan[p]);
            send_idle_pct = send_plan[p];
            recv_stall_pct = recv_plan[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 2 && i == ITEMS_PER_PHASE / 2) pause_until_drained();
                send_request($urandom_range(1) ? avr_pkg::FUNC_TICK : avr_pkg::FUNC_VERTEX,
                             pick_coord(), pick_coord(), pick_coord());
            end
            pause_until_drained();
        end

        if (sb.expected_q.size() != 0) begin
            sb.flag($sformatf("%0d vertices never came out", sb.expected_q.size()));
        end
        $display("checked %0d rotated vertices over %0d ticks (%0d angle wraps, final angle %0d)",
                 sb.vertices_checked, sb.ticks_seen, sb.angle_wraps, sb.angle);
        $display("%0d axis writes covering x, y, z and pass-through; %0d errors",
                 axis_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("vertex_axis_rotator_top_tb passed");
        end else begin
            $display("vertex_axis_rotator_top_tb failed");
        end
        $finish;
    end

endmodule
